// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_AW     = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // One table slot as stored in the RAM
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic        table_full;
    logic        all_done;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic        finished;
    logic        segment_start;
    logic        idle;
    logic [7:0]  running_id;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Channel  Dir  tdata                                   tuser
// in_      in   task_id, release_time, burst_length,    mode
//               task_priority
// out_     out  running_id, idle, segment_start,        -
//               finished, turnaround, waiting,
//               all_done, table_full
//
// An admit's result passes through ST_EMIT; a tick's result passes through
// ST_SCAN, which reads one table slot per cycle from the RAM, ST_FINISH and
// ST_EMIT. in_tready stays low until the result enters the output register.
// The winning slot is held in registers and written back after the scan.
// rst_n clears counters, time and the segment tracker; the table is not
// cleared and only slots below the loaded count are ever read.
// A stalled result waits in the output register while the next item runs;
// that item's result holds in ST_EMIT until the output register frees.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] task_id, [23:8] release_time, [39:24] burst_length, [47:40] task_priority
  input  logic [47:0] in_tdata,
  // [0] mode
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] running_id, [8] idle, [9] segment_start, [10] finished,
  // [26:11] turnaround, [42:27] waiting, [43] all_done, [44] table_full, [47:45] zero
  output logic [47:0] out_tdata
);

  pps_pkg::state_t state_r, state_nxt;

  logic [pps_pkg::CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [pps_pkg::CNT_W-1:0]   done_r, done_nxt;
  logic [15:0]                 time_r, time_nxt;
  logic [7:0]                  prev_id_r, prev_id_nxt;
  logic                        prev_vld_r, prev_vld_nxt;
  logic [pps_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [pps_pkg::SLOT_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic                        found_r, found_nxt;
  logic [pps_pkg::SLOT_AW-1:0] best_slot_r, best_slot_nxt;
  pps_pkg::slot_t              best_r, best_nxt;
  pps_pkg::res_t               res_r, res_nxt;
  pps_pkg::res_t               out_res_r, out_res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        ram_we;
  logic [pps_pkg::SLOT_AW-1:0] ram_waddr;
  pps_pkg::slot_t              ram_wdata;
  logic [pps_pkg::SLOT_AW-1:0] ram_raddr;
  pps_pkg::slot_t              ram_rdata;
  logic [pps_pkg::SLOT_W-1:0]  ram_rdata_raw;

  pps_pkg::slot_t              admit_slot;
  logic                        cand;
  logic [15:0]                 rem_dec;
  logic [16:0]                 span;
  logic [15:0]                 tat;
  logic [15:0]                 wait_t;

  pps_ram #(
    .WIDTH (pps_pkg::SLOT_W),
    .DEPTH (pps_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = pps_pkg::slot_t'(ram_rdata_raw);

  assign in_tready  = (state_r == pps_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  always_comb begin
    admit_slot.id        = in_tdata[7:0];
    admit_slot.arrival   = in_tdata[23:8];
    admit_slot.burst     = in_tdata[39:24];
    admit_slot.prio      = in_tdata[47:40];
    admit_slot.remaining = in_tdata[39:24];
  end

  // Candidate test for the slot whose read data is arriving this cycle
  assign cand = rd_vld_r && (ram_rdata.arrival <= time_r) && (ram_rdata.remaining != 16'd0) &&
                (!found_r || (ram_rdata.prio < best_r.prio));

  assign rem_dec = best_r.remaining - 16'd1;
  assign span    = {1'b0, time_r} + 17'd1 - {1'b0, best_r.arrival};
  assign tat     = span[16] ? pps_pkg::TIME_MAX : span[15:0];
  assign wait_t  = (tat >= best_r.burst) ? (tat - best_r.burst) : 16'd0;

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    done_nxt      = done_r;
    time_nxt      = time_r;
    prev_id_nxt   = prev_id_r;
    prev_vld_nxt  = prev_vld_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = idx_r[pps_pkg::SLOT_AW-1:0];
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = loaded_r[pps_pkg::SLOT_AW-1:0];
    ram_wdata     = admit_slot;
    ram_raddr     = idx_r[pps_pkg::SLOT_AW-1:0];

    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == pps_pkg::MODE_TICK) begin
            found_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = pps_pkg::ST_SCAN;
          end else begin
            res_nxt = '0;
            if (loaded_r >= pps_pkg::CNT_W'(pps_pkg::TABLE_DEPTH)) begin
              res_nxt.table_full = 1'b1;
            end else begin
              ram_we     = 1'b1;
              loaded_nxt = loaded_r + 1'b1;
              // zero burst counts as done at once
              if (admit_slot.burst == 16'd0) begin
                done_nxt = done_r + 1'b1;
              end
            end
            res_nxt.all_done = (done_nxt == loaded_nxt);
            state_nxt        = pps_pkg::ST_EMIT;
          end
        end
      end

      pps_pkg::ST_SCAN: begin
        if (cand) begin
          found_nxt     = 1'b1;
          best_slot_nxt = rd_idx_r;
          best_nxt      = ram_rdata;
        end
        if (idx_r < loaded_r) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = pps_pkg::ST_FINISH;
        end
      end

      pps_pkg::ST_FINISH: begin
        res_nxt = '0;
        if (found_r) begin
          ram_we                 = 1'b1;
          ram_waddr              = best_slot_r;
          ram_wdata              = best_r;
          ram_wdata.remaining    = rem_dec;
          res_nxt.running_id     = best_r.id;
          res_nxt.segment_start  = !prev_vld_r || (prev_id_r != best_r.id);
          prev_id_nxt            = best_r.id;
          prev_vld_nxt           = 1'b1;
          if (rem_dec == 16'd0) begin
            res_nxt.finished   = 1'b1;
            res_nxt.turnaround = tat;
            res_nxt.waiting    = wait_t;
            done_nxt           = done_r + 1'b1;
          end
        end else begin
          res_nxt.idle = 1'b1;
          prev_vld_nxt = 1'b0;
        end
        // saturate time at its maximum
        if (time_r != pps_pkg::TIME_MAX) begin
          time_nxt = time_r + 16'd1;
        end
        res_nxt.all_done = (done_nxt == loaded_r);
        state_nxt        = pps_pkg::ST_EMIT;
      end

      pps_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::ST_IDLE;
      loaded_r    <= '0;
      done_r      <= '0;
      time_r      <= '0;
      prev_id_r   <= '0;
      prev_vld_r  <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      done_r      <= done_nxt;
      time_r      <= time_nxt;
      prev_id_r   <= prev_id_nxt;
      prev_vld_r  <= prev_vld_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    best_slot_r <= best_slot_nxt;
    best_r      <= best_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

endmodule

// ===== hw/rtl/pps_ram.sv =====
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  preemptive_priority_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the task table and scheduler state
  logic [7:0]  shadow_id      [pps_pkg::TABLE_DEPTH];
  logic [15:0] shadow_arrival [pps_pkg::TABLE_DEPTH];
  logic [15:0] shadow_burst   [pps_pkg::TABLE_DEPTH];
  logic [7:0]  shadow_prio    [pps_pkg::TABLE_DEPTH];
  logic [15:0] shadow_left    [pps_pkg::TABLE_DEPTH];
  int unsigned loaded_cnt;
  int unsigned done_cnt;
  logic [15:0] now_tick;
  logic [7:0]  last_served_id;
  bit          last_served_valid;

  pps_pkg::res_t sched_reports[$];
  int   mismatch_count;
  int   sender_idle_pct;
  int   receiver_stall_pct;

  always #5 clk = ~clk;

  function automatic pps_pkg::res_t schedule_item(input logic mode, input logic [47:0] fields);
    pps_pkg::res_t               rep;
    logic [pps_pkg::SLOT_AW-1:0] slot;
    logic [pps_pkg::SLOT_AW-1:0] best;
    bit                          found;
    logic [16:0]                 span;
    logic [7:0]                  id;
    logic [15:0]                 burst;
    rep   = '0;
    slot  = '0;
    best  = '0;
    found = 1'b0;
    burst = fields[39:24];
    if (mode == pps_pkg::MODE_ADMIT) begin
      if (loaded_cnt >= pps_pkg::TABLE_DEPTH) begin
        rep.table_full = 1'b1;
      end else begin
        slot                 = pps_pkg::SLOT_AW'(loaded_cnt);
        shadow_id[slot]      = fields[7:0];
        shadow_arrival[slot] = fields[23:8];
        shadow_burst[slot]   = burst;
        shadow_prio[slot]    = fields[47:40];
        shadow_left[slot]    = burst;
        loaded_cnt++;
        // a zero-length task counts as done from the start
        if (burst == 16'd0) done_cnt++;
      end
    end else begin
      for (int unsigned i = 0; i < loaded_cnt; i++) begin
        slot = pps_pkg::SLOT_AW'(i);
        if (shadow_arrival[slot] <= now_tick && shadow_left[slot] != 16'd0 &&
            (!found || shadow_prio[slot] < shadow_prio[best])) begin
          found = 1'b1;
          best  = slot;
        end
      end
      if (found) begin
        id                    = shadow_id[best];
        rep.running_id        = id;
        rep.segment_start     = !last_served_valid || last_served_id != id;
        last_served_id        = id;
        last_served_valid     = 1'b1;
        shadow_left[best]     = shadow_left[best] - 16'd1;
        if (shadow_left[best] == 16'd0) begin
          span = {1'b0, now_tick} + 17'd1 - {1'b0, shadow_arrival[best]};
          if (span > {1'b0, pps_pkg::TIME_MAX}) span = {1'b0, pps_pkg::TIME_MAX};
          rep.finished   = 1'b1;
          rep.turnaround = span[15:0];
          rep.waiting    = (span >= {1'b0, shadow_burst[best]}) ?
                           span[15:0] - shadow_burst[best] : 16'd0;
          done_cnt++;
        end
      end else begin
        rep.idle          = 1'b1;
        last_served_valid = 1'b0;
      end
      if (now_tick != pps_pkg::TIME_MAX) now_tick = now_tick + 16'd1;
    end
    rep.all_done = (done_cnt == loaded_cnt);
    return rep;
  endfunction

  // Leaves tvalid high after the transfer so back-to-back items need no toggle
  task automatic send_item(input logic mode, input logic [47:0] fields);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= fields;
    do @(posedge clk); while (!in_tready);
    sched_reports.push_back(schedule_item(mode, fields));
  endtask

  task automatic admit_task(input logic [7:0] id, input logic [15:0] arrival,
                            input logic [15:0] burst, input logic [7:0] prio);
    send_item(pps_pkg::MODE_ADMIT, {prio, burst, arrival, id});
  endtask

  task automatic run_tick();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    send_item(pps_pkg::MODE_TICK, junk[47:0]);
  endtask

  task automatic admit_random_task();
    int          pick;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    pick = $urandom_range(99);
    if (pick < 10) begin
      burst = 16'd0;
      prio  = 8'($urandom_range(255));
    end else if (pick < 20) begin
      // keep long tasks at the back so short ones still finish
      burst = 16'($urandom_range(65535, 1));
      prio  = 8'($urandom_range(255, 200));
    end else begin
      burst = 16'($urandom_range(6, 1));
      prio  = (pick < 60) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    end
    // most tasks arrive soon so they get served within the run
    if ($urandom_range(99) < 75) arrival = now_tick + 16'($urandom_range(40));
    else arrival = 16'($urandom_range(65535));
    admit_task(8'($urandom_range(255)), arrival, burst, prio);
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sched_reports.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : report_check
    pps_pkg::res_t want;
    pps_pkg::res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        if (sched_reports.size() == 0) begin
          $error("result with nothing expected: 0x%0h", out_tdata);
          mismatch_count++;
        end else begin
          want = sched_reports.pop_front();
          got  = out_tdata[44:0];
          check_field("running_id", 16'(want.running_id), 16'(got.running_id));
          check_field("idle", 16'(want.idle), 16'(got.idle));
          check_field("segment_start", 16'(want.segment_start), 16'(got.segment_start));
          check_field("finished", 16'(want.finished), 16'(got.finished));
          check_field("turnaround", want.turnaround, got.turnaround);
          check_field("waiting", want.waiting, got.waiting);
          check_field("all_done", 16'(want.all_done), 16'(got.all_done));
          check_field("table_full", 16'(want.table_full), 16'(got.table_full));
          check_field("pad", 16'd0, 16'(out_tdata[47:45]));
        end
      end
    end
  end

  // Ties, duplicate ids, idle ticks and not-yet-arrived tasks at low time
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_tick();
    admit_task(8'h11, 16'd2, 16'd2, 8'd7);
    admit_task(8'h22, 16'd1, 16'd2, 8'd7);
    run_tick();
    run_tick();
    run_tick();
    admit_task(8'h22, 16'd0, 16'd1, 8'd7);
    run_tick();
    run_tick();
    run_tick();
    admit_task(8'h00, 16'hFFFF, 16'd3, 8'd255);
    run_tick();
    admit_task(8'hFF, 16'd0, 16'hFFFF, 8'd254);
    run_tick();
  endtask

  task automatic test_zero_burst();
    admit_task(8'h5A, 16'h1234, 16'd0, 8'd0);
    run_tick();
    admit_task(8'hA5, 16'hFFFF, 16'd2, 8'd0);
    run_tick();
    run_tick();
  endtask

  task automatic test_random_mix(input int items, input int idle_pct, input int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (items) begin
      if ($urandom_range(99) < 4) admit_random_task();
      else run_tick();
    end
    wait_for_reports();
  endtask

  task automatic test_table_full();
    while (loaded_cnt < pps_pkg::TABLE_DEPTH) admit_random_task();
    repeat (3) admit_random_task();
    run_tick();
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    in_tuser           = pps_pkg::MODE_ADMIT;
    loaded_cnt         = 0;
    done_cnt           = 0;
    now_tick           = '0;
    last_served_id     = '0;
    last_served_valid  = 1'b0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_burst();
    test_random_mix(460, 0, 0);
    test_random_mix(460, 65, 0);
    test_random_mix(460, 0, 65);
    test_random_mix(460, 29, 29);
    test_table_full();

    wait_for_reports();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("preemptive_priority_scheduler verification clean");
    end else begin
      $display("preemptive_priority_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("preemptive_priority_scheduler verification failed");
    $finish;
  end

endmodule
